@@ src/wbss_pkg.sv @@
// ----------------------------------------------------------------------------
// wbss_pkg: shared types and constants for the wildcard byte signature scan
// Holds the configuration bundle and the fixed field widths of the block.
// ----------------------------------------------------------------------------
package wbss_pkg;

  localparam int DATA_W     = 8;
  localparam int POS_OUT_W  = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 5;
  localparam int OFFSET_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd5;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] value_low;
    logic [CFG_DATA_W-1:0] value_high;
    logic [CFG_DATA_W-1:0] care_low;
    logic [CFG_DATA_W-1:0] care_high;
    logic [LEN_W-1:0]      length;
    logic [OFFSET_W-1:0]   start_offset;
  } wbss_cfg_t;

endpackage

@@ src/wbss_cfg.sv @@
// ----------------------------------------------------------------------------
// wbss_cfg: configuration register file
// Pattern value, care masks, length and start offset; write only.
// ----------------------------------------------------------------------------
module wbss_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [63:0]                 cfg_data,
  output wbss_pkg::wbss_cfg_t         cfg
);
  import wbss_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value_low    <= '0;
      cfg.value_high   <= '0;
      cfg.care_low     <= '1;
      cfg.care_high    <= '1;
      cfg.length       <= LEN_W'(1);
      cfg.start_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VALUE_LOW:  cfg.value_low    <= cfg_data;
        REG_VALUE_HIGH: cfg.value_high   <= cfg_data;
        REG_CARE_LOW:   cfg.care_low     <= cfg_data;
        REG_CARE_HIGH:  cfg.care_high    <= cfg_data;
        REG_LENGTH:     cfg.length       <= cfg_data[LEN_W-1:0];
        REG_OFFSET:     cfg.start_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ src/wbss_match.sv @@
// ----------------------------------------------------------------------------
// wbss_match: parallel masked compare of the window against the pattern
// Element k is checked against window byte len-1-k (newest byte at 0).
// ----------------------------------------------------------------------------
module wbss_match #(
  parameter int PATTERN_MAX = 16,
  parameter int FILL_W      = 5
) (
  input  logic [PATTERN_MAX*8-1:0] win,
  input  logic [FILL_W-1:0]        fill,
  input  logic [4:0]               len,
  input  logic [127:0]             value,
  input  logic [127:0]             care,
  output logic                     hit
);
  import wbss_pkg::*;

  logic [PATTERN_MAX-1:0] elem_ok;

  always_comb begin
    logic [DATA_W-1:0] sel;
    logic [LEN_W-1:0]  pos;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      sel = '0;
      pos = len - LEN_W'(k) - LEN_W'(1);
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (pos == LEN_W'(j)) begin
          sel = win[j*DATA_W +: DATA_W];
        end
      end
      elem_ok[k] = (LEN_W'(k) >= len) ||
                   ((sel & care[k*DATA_W +: DATA_W]) ==
                    (value[k*DATA_W +: DATA_W] & care[k*DATA_W +: DATA_W]));
    end
  end

  assign hit = (len != '0) && (LEN_W'(fill) >= len) && (&elem_ok);

endmodule

@@ src/wildcard_byte_signature_scan_top.sv @@
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_top: masked byte pattern search, per-bit wildcards
// Slides a window over the byte stream and reports the first match start or
// not-found at the last byte of each region.
// ----------------------------------------------------------------------------
// channel   | dir | handshake          | payload
// s_*       | in  | s_tvalid/s_tready  | s_tdata = data_byte, s_tlast = last_byte
// m_*       | out | m_tvalid/m_tready  | m_tdata = position, m_tuser = found
// cfg_*     | in  | cfg_we             | cfg_index, cfg_data
//
// One byte per cycle while results are taken: input register, one pass of parallel compares, result register.
// An input transaction passes the input register and then the result register.
// Reset clears the scan state and loads the register defaults; no clearing pass.
// A held result stalls the input register only when it is not taken that cycle.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan_top #(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] position
  output logic        m_tuser,   // [0] found
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import wbss_pkg::*;

  localparam int WIN_W  = PATTERN_MAX * DATA_W;
  localparam int FILL_W = $clog2(PATTERN_MAX + 1);
  localparam int CMP_W  = (POSITION_BITS > POS_OUT_W) ? POSITION_BITS : POS_OUT_W;
  localparam logic [POSITION_BITS-1:0] INDEX_MAX = '1;

  wbss_cfg_t cfg;

  logic                     in_valid;
  logic [DATA_W-1:0]        in_data;
  logic                     in_last;
  logic                     advance;

  logic [WIN_W-1:0]         win;
  logic [FILL_W-1:0]        fill;
  logic [POSITION_BITS-1:0] byte_index;
  logic                     match_reported;

  logic [WIN_W-1:0]         win_next;
  logic [FILL_W-1:0]        fill_next;
  logic [LEN_W-1:0]         eff_len;
  logic                     scan;
  logic                     hit;
  logic                     result_valid;
  logic [CMP_W-1:0]         diff;

  wbss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign eff_len = (cfg.length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : cfg.length;
  assign scan    = !match_reported &&
                   (CMP_W'(byte_index) >= CMP_W'(cfg.start_offset));

  always_comb begin
    win_next  = win;
    fill_next = fill;
    if (scan) begin
      win_next = WIN_W'({win, in_data});
      if (fill != FILL_W'(PATTERN_MAX)) begin
        fill_next = fill + FILL_W'(1);
      end
    end
  end

  wbss_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .FILL_W      (FILL_W)
  ) u_match (
    .win   (win_next),
    .fill  (fill_next),
    .len   (eff_len),
    .value ({cfg.value_high, cfg.value_low}),
    .care  ({cfg.care_high, cfg.care_low}),
    .hit   (hit)
  );

  assign result_valid = (scan && hit) || (in_last && !match_reported);
  assign diff         = CMP_W'(byte_index) - CMP_W'(eff_len) + CMP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      byte_index     <= '0;
      match_reported <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        fill           <= '0;
        byte_index     <= '0;
        match_reported <= 1'b0;
      end else begin
        fill           <= fill_next;
        match_reported <= match_reported || (scan && hit);
        if (byte_index != INDEX_MAX) begin
          byte_index <= byte_index + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result_valid) begin
      m_tuser <= scan && hit;
      m_tdata <= (scan && hit) ? diff[POS_OUT_W-1:0] : '0;
    end
  end

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found result carries a nonzero position");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(PATTERN_MAX))
    else $error("window fill beyond pattern capacity");

  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> !match_reported && fill == '0 && byte_index == '0)
    else $error("region state not cleared after last byte");

  a_single_report: assert property (@(posedge clk) disable iff (rst)
    advance && match_reported |-> !result_valid || in_last == 1'b0 || !hit)
    else $error("second report within one region");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    advance && result_valid |=> m_tvalid)
    else $error("result transaction lost");

endmodule
